>>> rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Shared constants, round tables and sequencer state type for the MD5 core.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  POS_MASK = 6'h3F;
  localparam logic [5:0]  LEN_POS = 6'd56;
  localparam int          BUF_DEPTH = 64;
  localparam int          ROUNDS = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } md5_state_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    logic [5:0] p;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: begin
        p = 6'(i * 6'd5) + 6'd1;
        g = p[3:0];
      end
      2'd2: begin
        p = 6'(i * 6'd3) + 6'd5;
        g = p[3:0];
      end
      default: begin
        p = 6'(i * 6'd7);
        g = p[3:0];
      end
    endcase
    return g;
  endfunction

endpackage

>>> rtl/md5_ram.sv
// ----------------------------------------------------------------------------
// MD5 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/md5_message_digest.sv
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 core with one shared round unit and a word buffer in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (data_byte, byte_present, last) carries one request per
//   byte; a request with byte_present low only advances on last.
//   A byte that neither completes a 64-byte block nor carries last is only
//   written into the buffer. A completed block goes through the accept step,
//   a prefetch step, 64 rounds (one round per cycle through the shared
//   adder/rotate unit) and a fold step.
//   On last the block writes padding one byte per cycle up to the end of
//   the block (twice when the length field does not fit), compresses once
//   or twice, then presents digest_low/digest_high on the output channel.
//   Ready is low from the accepted last request until the digest is taken;
//   a stalled output holds the digest and the block until taken, then it
//   re-initializes for the next message.
//   Reset sets the MD5 initial words and clears the byte count; the buffer
//   is not cleared since every read word is written first.
// ----------------------------------------------------------------------------
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_low,
  output logic [63:0] digest_high
);
  import md5_pkg::*;

  md5_state_t state, state_next;
  logic [31:0] ha, hb, hc, hd;
  logic [31:0] a, b, c, d;
  logic [60:0] byte_count;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic        finishing;
  logic        padded;
  logic        second;
  logic        prefetch;
  logic [31:0] wbuf [16];

  logic        acc;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic [3:0]  rd_addr;
  logic [31:0] rd_word;
  logic [63:0] bit_len;
  logic [31:0] f, t, rot;
  logic [4:0]  s;

  function automatic logic [31:0] wbuf_merge(input logic [1:0] lane, input logic [7:0] v,
                                             input logic [31:0] w);
    logic [31:0] r;
    r = w;
    r[8*lane +: 8] = v;
    return r;
  endfunction

  assign acc = valid && ready;
  assign bit_len = {byte_count, 3'b000};

  // byte buffer kept as 16 words written per byte lane
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wbuf[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_byte;
    end
  end

  md5_ram #(.WIDTH(32), .DEPTH(16)) u_word_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr[5:2]),
    .wdata (wbuf_merge(wr_addr[1:0], wr_byte, wbuf[wr_addr[5:2]])),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos;
    wr_byte = data_byte;
    if (state == ST_IDLE && acc && byte_present) begin
      wr_en = 1'b1;
    end else if (state == ST_PAD) begin
      wr_en = 1'b1;
      if (!second && pos == byte_count[5:0]) begin
        wr_byte = PAD_BYTE;
      end else if (pos >= LEN_POS && (second || byte_count[5:0] < LEN_POS - 6'd1 + 6'd1
                                      && byte_count[5:0] <= 6'd55)) begin
        wr_byte = bit_len[8*pos[2:0] +: 8];
      end else begin
        wr_byte = 8'h00;
      end
    end
  end

  assign rd_addr = (state == ST_ROUND && !prefetch) ? word_sel(6'(rnd + 6'd1)) : word_sel(rnd);

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s = rot_amt(rnd);
    t = a + f + rd_word + round_const(rnd);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (byte_present && pos == POS_MASK) begin
            state_next = ST_ROUND;
          end else if (last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD:  if (pos == POS_MASK) state_next = ST_ROUND;
      ST_ROUND: if (!prefetch && rnd == 6'(ROUNDS - 1)) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (!padded) begin
          state_next = ST_PAD;
        end else if (!second && byte_count[5:0] > 6'd55) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  assign digest_low = {hb, ha};
  assign digest_high = {hd, hc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ha <= INIT_A;
      hb <= INIT_B;
      hc <= INIT_C;
      hd <= INIT_D;
      byte_count <= '0;
      pos <= '0;
      rnd <= '0;
      finishing <= 1'b0;
      padded <= 1'b0;
      second <= 1'b0;
      prefetch <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            finishing <= last;
            padded <= 1'b0;
            second <= 1'b0;
            prefetch <= 1'b1;
            rnd <= '0;
            if (byte_present) begin
              byte_count <= byte_count + 61'd1;
              pos <= pos + 6'd1;
            end
            if (last && !(byte_present && pos == POS_MASK)) begin
              pos <= byte_present ? pos + 6'd1 : pos;
            end
          end
        end
        ST_PAD: begin
          pos <= pos + 6'd1;
          padded <= 1'b1;
          prefetch <= 1'b1;
          rnd <= '0;
        end
        ST_ROUND: begin
          if (prefetch) begin
            prefetch <= 1'b0;
            a <= ha;
            b <= hb;
            c <= hc;
            d <= hd;
          end else begin
            a <= d;
            d <= c;
            c <= b;
            b <= b + rot;
            rnd <= rnd + 6'd1;
          end
        end
        ST_FOLD: begin
          ha <= ha + a;
          hb <= hb + b;
          hc <= hc + c;
          hd <= hd + d;
          if (finishing && padded && !second && byte_count[5:0] > 6'd55) begin
            second <= 1'b1;
            pos <= '0;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            ha <= INIT_A;
            hb <= INIT_B;
            hc <= INIT_C;
            hd <= INIT_D;
            byte_count <= '0;
            pos <= '0;
            finishing <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // assertions
  a_out_only_finishing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> finishing) else $error("digest without end of message");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (ready && out_valid) == 1'b0) else $error("ready while digest pending");
  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (byte_count == '0 && pos == '0))
    else $error("no re-init after digest");

endmodule
